// ----- src/frwbc_pkg.sv -----
// ----------------------------------------------------------------------------
// Flash row write-back cache package
// Item types, field widths and access mode codes used by the cache module.
// ----------------------------------------------------------------------------
package frwbc_pkg;

  localparam int ADDR_W = 14;
  localparam int DATA_W = 8;
  localparam int MODE_W = 2;

  localparam logic [MODE_W-1:0] MODE_READ   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMMIT = 2'd2;

  localparam logic [DATA_W-1:0] ERASED_BYTE = 8'hFF;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              row_loaded;
    logic              row_written_back;
  } out_item_t;

endpackage

// ----- src/frwbc_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module frwbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/flash_row_write_back_cache.sv -----
// ----------------------------------------------------------------------------
// Flash row write-back cache
// Byte-addressed storage emulated over a flash array, with one row held in a
// write-back row buffer.
// ----------------------------------------------------------------------------
// Channel   Ports                     Handshake
// input     start, busy, in_item      taken when start is high and busy is low
// result    out_valid, out_item       one-cycle strobe, one result per item
//
// A hit on a write or a read goes straight to the row buffer when both row
// parameters are powers of two; otherwise one shared multiplier first splits
// the address by reciprocal multiplication. A commit of a clean row and an
// unused mode return a result without touching the row buffer. A miss adds a
// row fill and, if the cached row is dirty, a write-back before it; both walk
// the row one byte per cycle through the memory ports.
// After reset the flash array is erased one byte per cycle with busy high.
// ----------------------------------------------------------------------------
module flash_row_write_back_cache #(
  parameter int ROW_BYTES = 256,
  parameter int ROW_COUNT = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  frwbc_pkg::in_item_t  in_item,
  output logic                 busy,
  output logic                 out_valid,
  output frwbc_pkg::out_item_t out_item
);

  import frwbc_pkg::*;

  localparam int OFF_W       = $clog2(ROW_BYTES);
  localparam int ROW_W       = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int CNT_W       = $clog2(ROW_BYTES + 1);
  localparam int FLASH_DEPTH = ROW_BYTES * ROW_COUNT;
  localparam int FA_W        = $clog2(FLASH_DEPTH);
  localparam int Q1_S        = ADDR_W + $clog2(ROW_BYTES);
  localparam int Q1_M        = ((1 << Q1_S) + ROW_BYTES - 1) / ROW_BYTES;
  localparam int Q2_S        = ADDR_W + $clog2(ROW_COUNT);
  localparam int Q2_M        = ((1 << Q2_S) + ROW_COUNT - 1) / ROW_COUNT;
  localparam int MUL_W       = ADDR_W + 1;
  localparam int PROD_W      = ADDR_W + MUL_W;
  localparam bit FAST_DECODE = ((ROW_BYTES & (ROW_BYTES - 1)) == 0) &&
                               ((ROW_COUNT & (ROW_COUNT - 1)) == 0);

  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_DIV       = 4'd2;
  localparam logic [3:0] S_CHECK     = 4'd3;
  localparam logic [3:0] S_WB_BASE   = 4'd4;
  localparam logic [3:0] S_WB        = 4'd5;
  localparam logic [3:0] S_FILL_BASE = 4'd6;
  localparam logic [3:0] S_FILL      = 4'd7;
  localparam logic [3:0] S_ACCESS    = 4'd8;
  localparam logic [3:0] S_RD_WAIT   = 4'd9;

  logic [3:0]        state_r, state_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [DATA_W-1:0] wdata_r, wdata_nxt;
  logic [OFF_W-1:0]  offset_r, offset_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ROW_W-1:0]  cached_row_r, cached_row_nxt;
  logic              row_valid_r, row_valid_nxt;
  logic              row_dirty_r, row_dirty_nxt;
  logic              loaded_r, loaded_nxt;
  logic [FA_W-1:0]   base_r, base_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [OFF_W-1:0]  widx_r, widx_nxt;
  logic              wv_r, wv_nxt;
  logic [FA_W-1:0]   clr_r, clr_nxt;
  logic [1:0]        div_step_r, div_step_nxt;
  logic [ADDR_W-1:0] div_q_r, div_q_nxt;
  logic [ADDR_W-1:0] div_q2_r, div_q2_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic [OFF_W-1:0]  fast_off;
  logic [ROW_W-1:0]  fast_row;
  logic [ADDR_W-1:0] mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_p;
  logic              hit;

  logic              rb_we;
  logic [OFF_W-1:0]  rb_waddr;
  logic [DATA_W-1:0] rb_wdata;
  logic [OFF_W-1:0]  rb_raddr;
  logic [DATA_W-1:0] rb_rdata;
  logic              fl_we;
  logic [FA_W-1:0]   fl_waddr;
  logic [DATA_W-1:0] fl_wdata;
  logic [FA_W-1:0]   fl_raddr;
  logic [DATA_W-1:0] fl_rdata;

  frwbc_ram #(.WIDTH(DATA_W), .DEPTH(ROW_BYTES)) u_row_buffer (
    .clk   (clk),
    .we    (rb_we),
    .waddr (rb_waddr),
    .wdata (rb_wdata),
    .raddr (rb_raddr),
    .rdata (rb_rdata)
  );

  frwbc_ram #(.WIDTH(DATA_W), .DEPTH(FLASH_DEPTH)) u_flash_store (
    .clk   (clk),
    .we    (fl_we),
    .waddr (fl_waddr),
    .wdata (fl_wdata),
    .raddr (fl_raddr),
    .rdata (fl_rdata)
  );

  assign fast_off = in_item.address[OFF_W-1:0];
  assign fast_row = ROW_W'((in_item.address >> OFF_W) & ADDR_W'(ROW_COUNT - 1));

  always_comb begin
    unique case (div_step_r)
      2'd0: begin
        mul_a = addr_r;
        mul_b = MUL_W'(Q1_M);
      end
      2'd1: begin
        mul_a = div_q_r;
        mul_b = MUL_W'(ROW_BYTES);
      end
      2'd2: begin
        mul_a = div_q_r;
        mul_b = MUL_W'(Q2_M);
      end
      2'd3: begin
        mul_a = div_q2_r;
        mul_b = MUL_W'(ROW_COUNT);
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign hit = row_valid_r && (cached_row_r == row_r);

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    addr_nxt       = addr_r;
    wdata_nxt      = wdata_r;
    offset_nxt     = offset_r;
    row_nxt        = row_r;
    cached_row_nxt = cached_row_r;
    row_valid_nxt  = row_valid_r;
    row_dirty_nxt  = row_dirty_r;
    loaded_nxt     = loaded_r;
    base_nxt       = base_r;
    cnt_nxt        = cnt_r;
    widx_nxt       = widx_r;
    wv_nxt         = 1'b0;
    clr_nxt        = clr_r;
    div_step_nxt   = div_step_r;
    div_q_nxt      = div_q_r;
    div_q2_nxt     = div_q2_r;
    out_valid_nxt  = 1'b0;
    out_item_nxt   = out_item_r;

    rb_we    = 1'b0;
    rb_waddr = widx_r;
    rb_wdata = fl_rdata;
    rb_raddr = cnt_r[OFF_W-1:0];
    fl_we    = 1'b0;
    fl_waddr = base_r + FA_W'(widx_r);
    fl_wdata = rb_rdata;
    fl_raddr = base_r + FA_W'(cnt_r);

    unique case (state_r)
      S_CLEAR: begin
        fl_we    = 1'b1;
        fl_waddr = clr_r;
        fl_wdata = ERASED_BYTE;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == FA_W'(FLASH_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          mode_nxt   = in_item.mode;
          addr_nxt   = in_item.address;
          wdata_nxt  = in_item.write_data;
          loaded_nxt = 1'b0;
          unique case (in_item.mode)
            MODE_READ, MODE_WRITE: begin
              if (FAST_DECODE) begin
                offset_nxt = fast_off;
                row_nxt    = fast_row;
                state_nxt  = S_CHECK;
              end else begin
                div_step_nxt = '0;
                state_nxt    = S_DIV;
              end
            end
            MODE_COMMIT: begin
              state_nxt = S_CHECK;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_item_nxt  = '0;
            end
          endcase
        end
      end
      S_DIV: begin
        div_step_nxt = div_step_r + 1'b1;
        unique case (div_step_r)
          2'd0: begin
            div_q_nxt = ADDR_W'(mul_p >> Q1_S);
          end
          2'd1: begin
            offset_nxt = OFF_W'(addr_r - ADDR_W'(mul_p));
          end
          2'd2: begin
            div_q2_nxt = ADDR_W'(mul_p >> Q2_S);
          end
          2'd3: begin
            row_nxt   = ROW_W'(div_q_r - ADDR_W'(mul_p));
            state_nxt = S_CHECK;
          end
        endcase
      end
      S_CHECK: begin
        if (mode_r == MODE_COMMIT) begin
          if (row_valid_r && row_dirty_r) begin
            state_nxt = S_WB_BASE;
          end else begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '0;
            state_nxt     = S_IDLE;
          end
        end else if (hit) begin
          state_nxt = S_ACCESS;
        end else if (row_valid_r && row_dirty_r) begin
          state_nxt = S_WB_BASE;
        end else begin
          out_item_nxt = '0;
          state_nxt    = S_FILL_BASE;
        end
      end
      S_WB_BASE: begin
        base_nxt  = FA_W'(cached_row_r) * FA_W'(ROW_BYTES);
        cnt_nxt   = '0;
        state_nxt = S_WB;
      end
      S_WB: begin
        rb_raddr = cnt_r[OFF_W-1:0];
        fl_we    = wv_r;
        wv_nxt   = (cnt_r < CNT_W'(ROW_BYTES));
        widx_nxt = cnt_r[OFF_W-1:0];
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROW_BYTES)) begin
          wv_nxt        = 1'b0;
          row_dirty_nxt = 1'b0;
          if (mode_r == MODE_COMMIT) begin
            out_valid_nxt                 = 1'b1;
            out_item_nxt                  = '0;
            out_item_nxt.row_written_back = 1'b1;
            state_nxt                     = S_IDLE;
          end else begin
            out_item_nxt                  = '0;
            out_item_nxt.row_written_back = 1'b1;
            state_nxt                     = S_FILL_BASE;
          end
        end
      end
      S_FILL_BASE: begin
        base_nxt  = FA_W'(row_r) * FA_W'(ROW_BYTES);
        cnt_nxt   = '0;
        state_nxt = S_FILL;
      end
      S_FILL: begin
        fl_raddr = base_r + FA_W'(cnt_r);
        rb_we    = wv_r;
        wv_nxt   = (cnt_r < CNT_W'(ROW_BYTES));
        widx_nxt = cnt_r[OFF_W-1:0];
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROW_BYTES)) begin
          wv_nxt         = 1'b0;
          cached_row_nxt = row_r;
          row_valid_nxt  = 1'b1;
          loaded_nxt     = 1'b1;
          state_nxt      = S_ACCESS;
        end
      end
      S_ACCESS: begin
        rb_raddr = offset_r;
        if (mode_r == MODE_READ) begin
          state_nxt = S_RD_WAIT;
        end else begin
          rb_we                         = 1'b1;
          rb_waddr                      = offset_r;
          rb_wdata                      = wdata_r;
          row_dirty_nxt                 = 1'b1;
          out_valid_nxt                 = 1'b1;
          out_item_nxt.read_data        = '0;
          out_item_nxt.row_loaded       = loaded_r;
          out_item_nxt.row_written_back = loaded_r && out_item_r.row_written_back;
          state_nxt                     = S_IDLE;
        end
      end
      S_RD_WAIT: begin
        out_valid_nxt                 = 1'b1;
        out_item_nxt.read_data        = rb_rdata;
        out_item_nxt.row_loaded       = loaded_r;
        out_item_nxt.row_written_back = loaded_r && out_item_r.row_written_back;
        state_nxt                     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      cached_row_r <= '0;
      row_valid_r  <= 1'b0;
      row_dirty_r  <= 1'b0;
      loaded_r     <= 1'b0;
      wv_r         <= 1'b0;
      cnt_r        <= '0;
      div_step_r   <= '0;
      out_valid_r  <= 1'b0;
      out_item_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      cached_row_r <= cached_row_nxt;
      row_valid_r  <= row_valid_nxt;
      row_dirty_r  <= row_dirty_nxt;
      loaded_r     <= loaded_nxt;
      wv_r         <= wv_nxt;
      cnt_r        <= cnt_nxt;
      div_step_r   <= div_step_nxt;
      out_valid_r  <= out_valid_nxt;
      out_item_r   <= out_item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    addr_r    <= addr_nxt;
    wdata_r   <= wdata_nxt;
    offset_r  <= offset_nxt;
    row_r     <= row_nxt;
    base_r    <= base_nxt;
    widx_r    <= widx_nxt;
    div_q_r   <= div_q_nxt;
    div_q2_r  <= div_q2_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Every accepted item either keeps the block busy or has its result showing.
  a_item_not_lost : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted item neither in progress nor delivered");

  // A dirty mark is only ever held for a cached row.
  a_dirty_needs_valid : assert property (@(posedge clk) disable iff (!rst_n)
    row_dirty_r |-> row_valid_r)
    else $error("row buffer dirty without a cached row");

  // A reported fill leaves a valid cached row behind.
  a_fill_sets_valid : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.row_loaded) |-> row_valid_r)
    else $error("row fill reported but no row cached");

  // A write-back without a fill leaves the row buffer clean.
  a_writeback_cleans : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.row_written_back && !out_item.row_loaded) |-> !row_dirty_r)
    else $error("row still dirty after a commit write-back");

endmodule
